// ===== rtl/core/drnm_pkg.sv =====
// shared types and constants for the delta-r nearest match block
package drnm_pkg;

	localparam int ETA_W     = 16;
	localparam int PHI_W     = 15;
	localparam int D2_W      = 33;
	localparam int INDEX_W   = 6;
	localparam int FRAC_BITS = 12;
	localparam int ENTRY_W   = ETA_W + PHI_W;
	localparam int MAG_W     = ETA_W;
	localparam int SQ_W      = 2 * MAG_W;
	localparam int DPHI_W    = PHI_W + 2;

	// pi rounded from a 30 fractional bit value down to FRAC_BITS
	localparam logic [63:0] PI_Q30 = 64'd3373259426;
	localparam logic [63:0] PI_RND = (PI_Q30 + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
	localparam logic signed [DPHI_W-1:0] PI_FX      = DPHI_W'(PI_RND);
	localparam logic signed [DPHI_W-1:0] NEG_PI_FX  = -PI_FX;
	localparam logic signed [DPHI_W-1:0] TWO_PI_FX  = DPHI_W'(2 * PI_RND);

	localparam logic [D2_W-1:0] D2_MAX       = {D2_W{1'b1}};
	localparam logic [D2_W-1:0] RADIUS_RESET = D2_W'(1678);

	// input kinds
	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// register index, taken from paddr[3]
	localparam logic REG_RADIUS = 1'b0;

	typedef struct packed {
		logic load;
		logic start;
		logic issue;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic empty;
		logic scan_last;
		logic pipe_busy;
	} dp_status_t;

	// packed so match_valid sits in the lowest bit
	typedef struct packed {
		logic [D2_W-1:0]    best_distance_sq;
		logic [INDEX_W-1:0] match_index;
		logic               match_valid;
	} result_t;

endpackage

// ===== rtl/core/drnm_ctrl.sv =====
// sequencing of loads, table scans and result hand-off
module drnm_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic                   kind,
	input  logic                   out_free,
	input  drnm_pkg::dp_status_t   status,
	output logic                   s_tready,
	output drnm_pkg::ctrl_cmd_t    cmd
);
	import drnm_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   accept;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		cmd.load   = accept && (kind == KIND_LOAD);
		cmd.start  = accept && (kind == KIND_QUERY);
		cmd.issue  = (state_q == ST_SCAN);
		cmd.finish = (state_q == ST_FINISH) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (kind == KIND_QUERY)) begin
						// an empty table has nothing to scan
						state_q <= status.empty ? ST_FINISH : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (status.scan_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!status.pipe_busy) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/drnm_dp.sv =====
// reference table memory, distance pipeline and best-match tracking
module drnm_dp #(
	parameter int MAX_REFS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  drnm_pkg::ctrl_cmd_t           cmd,
	output drnm_pkg::dp_status_t          status,
	input  logic                          first_of_set,
	input  logic [drnm_pkg::ETA_W-1:0]    eta,
	input  logic [drnm_pkg::PHI_W-1:0]    phi,
	input  logic [drnm_pkg::D2_W-1:0]     match_radius_sq,
	output drnm_pkg::result_t             result
);
	import drnm_pkg::*;

	localparam int IW = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;
	localparam int CW = $clog2(MAX_REFS + 1);

	logic [CW-1:0]      count_q;
	logic [CW-1:0]      wr_base;
	logic               wr_en;
	logic [ENTRY_W-1:0] ref_mem [MAX_REFS];

	logic [IW-1:0]      scan_addr_q;
	logic [ETA_W-1:0]   q_eta_q;
	logic [PHI_W-1:0]   q_phi_q;

	logic [ENTRY_W-1:0] rd_entry_s1;
	logic [ETA_W-1:0]   rd_eta;
	logic [PHI_W-1:0]   rd_phi;
	logic               valid_s1, valid_s2, valid_s3;
	logic [IW-1:0]      idx_s1, idx_s2, idx_s3;

	logic [ETA_W:0]            deta;
	logic signed [PHI_W:0]     dphi_raw;
	logic signed [DPHI_W-1:0]  dphi_ext;
	logic signed [DPHI_W-1:0]  dphi_wrap;
	logic [ETA_W:0]            deta_s2;
	logic [DPHI_W-1:0]         dphi_s2;

	logic [ETA_W:0]     eta_abs;
	logic [DPHI_W-1:0]  phi_abs;
	logic [MAG_W-1:0]   eta_mag, phi_mag;
	logic [SQ_W-1:0]    sq_eta_s3, sq_phi_s3;

	logic [D2_W-1:0]    d2;
	logic [D2_W-1:0]    best_q;
	logic [IW-1:0]      best_idx_q;
	logic               found_q;
	logic [IW+INDEX_W-1:0] idx_ext;

	// table writes
	assign wr_base = first_of_set ? '0 : count_q;
	assign wr_en   = cmd.load && (first_of_set || (count_q < CW'(MAX_REFS)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (wr_en) begin
			count_q <= wr_base + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ref_mem[wr_base[IW-1:0]] <= {phi, eta};
		end
		rd_entry_s1 <= ref_mem[scan_addr_q];
	end

	// scan address and query latch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_addr_q <= '0;
		end else if (cmd.start) begin
			scan_addr_q <= '0;
		end else if (cmd.issue) begin
			scan_addr_q <= scan_addr_q + IW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			q_eta_q <= eta;
			q_phi_q <= phi;
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= cmd.issue;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// differences and phi wrap
	assign rd_eta   = rd_entry_s1[ETA_W-1:0];
	assign rd_phi   = rd_entry_s1[ENTRY_W-1:ETA_W];
	assign deta     = {q_eta_q[ETA_W-1], q_eta_q} - {rd_eta[ETA_W-1], rd_eta};
	assign dphi_raw = $signed({q_phi_q[PHI_W-1], q_phi_q}) - $signed({rd_phi[PHI_W-1], rd_phi});
	assign dphi_ext = {dphi_raw[PHI_W], dphi_raw};

	always_comb begin
		priority if (dphi_ext < NEG_PI_FX) begin
			dphi_wrap = dphi_ext + TWO_PI_FX;
		end else if (dphi_ext > PI_FX) begin
			dphi_wrap = dphi_ext - TWO_PI_FX;
		end else begin
			dphi_wrap = dphi_ext;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= scan_addr_q;
		idx_s2  <= idx_s1;
		idx_s3  <= idx_s2;
		deta_s2 <= deta;
		dphi_s2 <= dphi_wrap;
	end

	// squares
	assign eta_abs = deta_s2[ETA_W] ? (~deta_s2 + (ETA_W+1)'(1)) : deta_s2;
	assign phi_abs = dphi_s2[DPHI_W-1] ? (~dphi_s2 + DPHI_W'(1)) : dphi_s2;
	assign eta_mag = eta_abs[MAG_W-1:0];
	assign phi_mag = phi_abs[MAG_W-1:0];

	always_ff @(posedge clk) begin
		sq_eta_s3 <= eta_mag * eta_mag;
		sq_phi_s3 <= phi_mag * phi_mag;
	end

	// running minimum, earliest entry keeps a tie
	assign d2 = D2_W'(sq_eta_s3) + D2_W'(sq_phi_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.start) begin
			found_q <= 1'b0;
		end else if (valid_s3) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			best_q <= D2_MAX;
		end else if (valid_s3 && (!found_q || (d2 < best_q))) begin
			best_q     <= d2;
			best_idx_q <= idx_s3;
		end
	end

	assign idx_ext = {{INDEX_W{1'b0}}, best_idx_q};

	always_comb begin
		result.match_valid      = found_q && (best_q < match_radius_sq);
		result.match_index      = result.match_valid ? idx_ext[INDEX_W-1:0] : '0;
		result.best_distance_sq = best_q;
	end

	always_comb begin
		status.empty     = (count_q == '0);
		status.scan_last = (CW'(scan_addr_q) == (count_q - CW'(1)));
		status.pipe_busy = valid_s1 || valid_s2 || valid_s3;
	end

	a_load_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !(valid_s1 || valid_s2 || valid_s3))
		else $error("table load while distance pipeline holds entries");

	a_issue_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> (CW'(scan_addr_q) < count_q))
		else $error("scan address beyond stored entries");

	a_result_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> (CW'(idx_s3) < count_q))
		else $error("distance result for an entry that is not stored");

endmodule

// ===== rtl/core/delta_r_nearest_match.sv =====
// top level: stream ports, radius register, result register
// A load word writes one table entry in the cycle it is accepted (none when the table is
// full and the word does not start a new set), and the block is ready again in the next
// cycle. A query word scans the stored entries (at most MAX_REFS) with one distance unit
// that reads one table entry per cycle from a single memory read port; a query on an
// empty table skips the scan and goes straight to the finish state. The next word is
// taken while the result still waits in the output register. The table has no reset
// contents and needs no clearing pass; the stored entry count resets to zero. The
// radius register is 33 bits at byte address 0.
module delta_r_nearest_match #(
	parameter int MAX_REFS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// config port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	// input words
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // eta[15:0], phi[30:16], zero[31]
	input  logic [1:0]  s_tuser,   // kind[0], first_of_set[1]
	// result words
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // match_valid[0], match_index[6:1], best_distance_sq[39:7]
);
	import drnm_pkg::*;

	logic [D2_W-1:0] radius_q;
	logic            cfg_wr;
	ctrl_cmd_t       cmd;
	dp_status_t      status;
	result_t         result;
	logic            out_free;
	logic            out_valid_q;
	result_t         out_data_q;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[3] == REG_RADIUS);
	assign prdata = (paddr[3] == REG_RADIUS) ? {{(64-D2_W){1'b0}}, radius_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
		end else if (cfg_wr) begin
			radius_q <= pwdata[D2_W-1:0];
		end
	end

	drnm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.kind     (s_tuser[0]),
		.out_free (out_free),
		.status   (status),
		.s_tready (s_tready),
		.cmd      (cmd)
	);

	drnm_dp #(
		.MAX_REFS (MAX_REFS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.first_of_set    (s_tuser[1]),
		.eta             (s_tdata[ETA_W-1:0]),
		.phi             (s_tdata[ENTRY_W-1:ETA_W]),
		.match_radius_sq (radius_q),
		.result          (result)
	);

	// output register frees the datapath as soon as the word is captured
	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_data_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

// ===== test/testbench.sv =====
// testbench for the delta-r nearest match block: directed and random stream traffic, plus radius register accesses
module testbench;
	import drnm_pkg::*;

	localparam int         TAB_DEPTH  = 64;
	localparam longint     HALF_TURN  = 12868;
	localparam longint     FULL_TURN  = 2 * HALF_TURN;
	localparam longint     DIST_LIMIT = 64'h1_FFFF_FFFF;
	localparam logic [3:0] RADIUS_ADDR = {REG_RADIUS, 3'b000};

	typedef struct packed {
		logic [32:0] dist_sq;
		logic [5:0]  idx;
		logic        hit;
	} match_word_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [3:0]  paddr;
	logic [63:0] pwdata, prdata;
	logic        pready;
	logic        s_tvalid, s_tready;
	logic [31:0] s_tdata;   // eta[15:0], phi[30:16], zero[31]
	logic [1:0]  s_tuser;   // kind[0], first_of_set[1]
	logic        m_tvalid, m_tready;
	logic [39:0] m_tdata;   // match_valid[0], match_index[6:1], best_distance_sq[39:7]

	// mirror of the block state
	logic signed [15:0] tab_eta [TAB_DEPTH];
	logic signed [14:0] tab_phi [TAB_DEPTH];
	int                 tab_count = 0;
	logic [32:0]        radius = RADIUS_RESET;

	match_word_t pending_matches[$];
	match_word_t want;
	int          error_count = 0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;

	delta_r_nearest_match i_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#20_000_000;
		$display("testbench failed");
		$finish;
	end

	// scan the mirrored table for the entry nearest to the query
	function automatic match_word_t nearest_match(logic signed [15:0] q_eta,
			logic signed [14:0] q_phi);
		match_word_t w;
		longint      deta, dphi, d2, best;
		int          best_idx;
		bit          found;
		best = DIST_LIMIT;
		best_idx = 0;
		found = 1'b0;
		for (int i = 0; i < tab_count; i++) begin
			deta = longint'(q_eta) - longint'(tab_eta[i]);
			dphi = longint'(q_phi) - longint'(tab_phi[i]);
			if (dphi < -HALF_TURN) begin
				dphi += FULL_TURN;
			end else if (dphi > HALF_TURN) begin
				dphi -= FULL_TURN;
			end
			d2 = deta * deta + dphi * dphi;
			if (d2 > DIST_LIMIT) begin
				d2 = DIST_LIMIT;
			end
			if (!found || d2 < best) begin
				found = 1'b1;
				best = d2;
				best_idx = i;
			end
		end
		w.hit     = found && (best < longint'(radius));
		w.idx     = w.hit ? best_idx[5:0] : 6'd0;
		w.dist_sq = best[32:0];
		return w;
	endfunction

	function automatic void store_entry(logic first, logic [15:0] eta, logic [14:0] phi);
		if (first) begin
			tab_count = 0;
		end
		if (tab_count < TAB_DEPTH) begin
			tab_eta[tab_count] = eta;
			tab_phi[tab_count] = phi;
			tab_count++;
		end
	endfunction

	function automatic logic [15:0] jitter_eta(logic [15:0] c, int spread);
		return c + 16'(int'($urandom_range(2 * spread)) - spread);
	endfunction

	function automatic logic [14:0] jitter_phi(logic [14:0] c, int spread);
		return c + 15'(int'($urandom_range(2 * spread)) - spread);
	endfunction

	// mostly inside [-pi, pi], now and then anywhere in the field
	function automatic logic [14:0] random_phi();
		if ($urandom_range(99) < 85) begin
			return 15'(int'($urandom_range(FULL_TURN)) - HALF_TURN);
		end
		return 15'($urandom());
	endfunction

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_matches.size() == 0) begin
				$error("result word %h with no query outstanding", m_tdata);
				error_count++;
			end else begin
				want = pending_matches.pop_front();
				if (m_tdata[0] !== want.hit) begin
					$error("match_valid: expected %0d, got %0d", want.hit, m_tdata[0]);
					error_count++;
				end
				if (m_tdata[6:1] !== want.idx) begin
					$error("match_index: expected %0d, got %0d", want.idx, m_tdata[6:1]);
					error_count++;
				end
				if (m_tdata[39:7] !== want.dist_sq) begin
					$error("best_distance_sq: expected %0d, got %0d", want.dist_sq,
						m_tdata[39:7]);
					error_count++;
				end
			end
		end
	end

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_word(input logic kind, input logic first, input logic [15:0] eta,
			input logic [14:0] phi);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, phi, eta};
		s_tuser  <= {first, kind};
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		if (kind == KIND_QUERY) begin
			pending_matches.push_back(nearest_match(eta, phi));
		end else begin
			store_entry(first, eta, phi);
		end
		@(negedge clk);
	endtask

	task automatic query_near(input int spread);
		int          j;
		logic [14:0] base_phi;
		if (tab_count == 0) begin
			send_word(KIND_QUERY, 1'($urandom()), 16'($urandom()), random_phi());
		end else begin
			j = $urandom_range(tab_count - 1);
			base_phi = tab_phi[j];
			// sometimes land on the other side of the phi seam
			if ($urandom_range(9) == 0) begin
				base_phi = (tab_phi[j] >= 0) ? 15'(tab_phi[j] - FULL_TURN)
					: 15'(tab_phi[j] + FULL_TURN);
			end
			send_word(KIND_QUERY, 1'($urandom()), jitter_eta(tab_eta[j], spread),
				jitter_phi(base_phi, spread));
		end
	endtask

	// no stream traffic left in flight
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_matches.size() != 0) begin
			@(negedge clk);
		end
		repeat (8) @(negedge clk);
	endtask

	task automatic apb_access(input logic write, input logic [32:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= write;
		paddr   <= RADIUS_ADDR;
		pwdata  <= {31'd0, value};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		if (write) begin
			radius = value;
		end else if (prdata[32:0] !== radius) begin
			$error("match_radius_sq: expected %0d, got %0d", radius, prdata[32:0]);
			error_count++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_radius(input logic [32:0] value);
		drain();
		apb_access(1'b1, value);
		apb_access(1'b0, '0);
	endtask

	task automatic test_directed();
		// empty table
		send_word(KIND_QUERY, 1'b1, 16'sd0, 15'sd0);
		send_word(KIND_QUERY, 1'b0, 16'h8000, 15'h4000);
		// field extremes, duplicates
		send_word(KIND_LOAD, 1'b1, 16'sd32767, 15'sd12868);
		send_word(KIND_LOAD, 1'b0, 16'h8000, -15'sd12868);
		send_word(KIND_LOAD, 1'b0, 16'sd0, 15'sd0);
		send_word(KIND_LOAD, 1'b0, 16'sd0, 15'sd0);
		send_word(KIND_LOAD, 1'b0, 16'hffff, 15'h7fff);
		send_word(KIND_QUERY, 1'b0, 16'sd0, 15'sd0);
		// across the phi seam
		send_word(KIND_QUERY, 1'b0, 16'h8000, 15'sd12868);
		send_word(KIND_QUERY, 1'b0, 16'sd32767, -15'sd12860);
		// phi outside its stated range
		send_word(KIND_QUERY, 1'b0, 16'sd32767, 15'h4000);
		send_word(KIND_QUERY, 1'b0, 16'h8000, 15'h3fff);
		send_word(KIND_QUERY, 1'b1, 16'sd32767, 15'sd0);
		// equal distances, earliest entry wins
		send_word(KIND_LOAD, 1'b1, 16'sd100, 15'sd200);
		send_word(KIND_LOAD, 1'b0, 16'sd120, 15'sd200);
		send_word(KIND_LOAD, 1'b0, 16'sd80, 15'sd200);
		send_word(KIND_QUERY, 1'b0, 16'sd110, 15'sd200);
		send_word(KIND_QUERY, 1'b0, 16'sd90, 15'sd200);
		send_word(KIND_QUERY, 1'b1, 16'sd100, 15'sd230);
		send_word(KIND_QUERY, 1'b0, 16'sd100, 15'sd241);
		drain();
	endtask

	task automatic test_radius_register();
		apb_access(1'b0, '0);
		set_radius(33'h1_ffff_ffff);
		send_word(KIND_LOAD, 1'b1, 16'sd32767, 15'sd0);
		send_word(KIND_QUERY, 1'b0, 16'h8000, 15'sd12868);
		send_word(KIND_QUERY, 1'b0, 16'sd0, 15'sd0);
		set_radius(33'd0);
		send_word(KIND_QUERY, 1'b0, 16'sd32767, 15'sd0);
		set_radius(33'd1);
		send_word(KIND_QUERY, 1'b0, 16'sd32767, 15'sd0);
		// distance exactly at the radius does not match
		set_radius(33'd100);
		send_word(KIND_QUERY, 1'b0, 16'sd32757, 15'sd0);
		set_radius(33'd101);
		send_word(KIND_QUERY, 1'b0, 16'sd32757, 15'sd0);
		set_radius(RADIUS_RESET);
	endtask

	task automatic test_table_capacity();
		logic [15:0] eta;
		logic [14:0] phi;
		for (int i = 0; i < TAB_DEPTH + 3; i++) begin
			send_word(KIND_LOAD, i == 0, 16'($urandom()), random_phi());
		end
		send_word(KIND_QUERY, 1'b0, tab_eta[TAB_DEPTH - 1], tab_phi[TAB_DEPTH - 1]);
		send_word(KIND_QUERY, 1'b0, jitter_eta(tab_eta[0], 30), jitter_phi(tab_phi[0], 30));
		eta = $urandom();
		phi = random_phi();
		send_word(KIND_LOAD, 1'b1, eta, phi);
		send_word(KIND_QUERY, 1'b0, eta, phi);
		drain();
	endtask

	task automatic test_random(input int items);
		int          sent, n, nq, spread, pick;
		logic [15:0] c_eta;
		logic [14:0] c_phi;
		sent = 0;
		while (sent < items) begin
			pick = $urandom_range(99);
			if (pick < 80) begin
				// a fresh reference set, then queries against it
				n = ($urandom_range(9) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 12);
				nq = $urandom_range(1, 6);
				case ($urandom_range(2))
					0: spread = 64;
					1: spread = 2048;
					default: spread = 32767;
				endcase
				c_eta = $urandom();
				c_phi = random_phi();
				for (int i = 0; i < n; i++) begin
					send_word(KIND_LOAD, i == 0, jitter_eta(c_eta, spread),
						jitter_phi(c_phi, spread));
				end
				for (int i = 0; i < nq; i++) begin
					query_near($urandom_range(1) ? 40 : spread);
				end
				sent += n + nq;
			end else if (pick < 92) begin
				send_word(1'($urandom()), $urandom_range(7) == 0, 16'($urandom()),
					15'($urandom()));
				sent++;
			end else begin
				// set cut short to one entry
				send_word(KIND_LOAD, 1'b1, 16'($urandom()), random_phi());
				query_near($urandom_range(1) ? 0 : 500);
				sent += 2;
			end
		end
	endtask

	initial begin
		arst_n   = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		m_tready = 1'b0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle_pct = 25;
		recv_idle_pct = 45;
		test_directed();
		test_radius_register();
		test_table_capacity();
		test_random(300);
		set_radius(33'($urandom_range(200000, 4000000)));
		send_idle_pct = 45;
		recv_idle_pct = 25;
		test_random(300);
		set_radius({1'($urandom()), 32'($urandom())});
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(150);
		set_radius(RADIUS_RESET);
		test_random(150);
		drain();
		repeat (80) @(negedge clk);

		if (error_count == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

endmodule
